>>> sv/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg: shared types and constants of the FIR convolution filter
// Fixed field widths, command codes and the per-cell control group.
// ----------------------------------------------------------------------------
package fcf_pkg;

   localparam int unsigned Y_WIDTH   = 38;
   localparam int unsigned IDX_WIDTH = 6;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } fcf_cmd_type;

   typedef struct packed {
      logic load;
      logic shift;
   } fcf_ctl_type;

endpackage

>>> sv/fcf_cell.sv
// ----------------------------------------------------------------------------
// fcf_cell: one tap of the FIR chain
// Holds one coefficient and one delayed sample, forms their product and adds
// it to the partial sum handed over by the previous cell.
// ----------------------------------------------------------------------------
module fcf_cell
   import fcf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fcf_ctl_type                    ctl,
   input  logic signed [COEF_WIDTH-1:0]   coef_in,
   input  logic signed [SAMPLE_WIDTH-1:0] tap_in,
   output logic signed [SAMPLE_WIDTH-1:0] tap_out,
   input  logic signed [Y_WIDTH-1:0]      sum_in,
   input  logic                           vld_in,
   output logic signed [Y_WIDTH-1:0]      sum_out,
   output logic                           vld_out
);

   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;

   logic signed [COEF_WIDTH-1:0]   coef_ff;
   logic signed [SAMPLE_WIDTH-1:0] tap_ff;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic signed [Y_WIDTH-1:0]      sum_ff;
   logic                           vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         tap_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         if (ctl.load) begin
            coef_ff <= coef_in;
         end
         if (ctl.shift) begin
            tap_ff <= tap_in;
         end
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_WIDTH'(coef_ff) * PROD_WIDTH'(tap_ff);
      sum_ff  <= sum_in + Y_WIDTH'(prod_ff);
   end

   assign tap_out = tap_ff;
   assign sum_out = sum_ff;
   assign vld_out = vld_ff;

endmodule

>>> sv/fir_convolution_filter.sv
// ----------------------------------------------------------------------------
// fir_convolution_filter: direct-form FIR convolution over a chain of taps
// A sample transfer launches a pass in which the partial sum walks the tap
// chain one cell per cycle; the result is then registered for the response.
// Requests are taken only while idle, after the last result has moved to the response register.
// Reset clears all coefficients and the delay line to zero.
// ----------------------------------------------------------------------------
module fir_convolution_filter
   import fcf_pkg::*;
#(
   parameter int TAPS         = 60,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [IDX_WIDTH-1:0]           req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]   req_coef_value,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [Y_WIDTH-1:0]      rsp_y
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic                           start_ff, start_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [Y_WIDTH-1:0]      rsp_y_ff, rsp_y_in;
   logic signed [Y_WIDTH-1:0]      acc_ff, acc_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                           shift;
   logic                           req_fire;

   logic signed [SAMPLE_WIDTH-1:0] tap_c [0:TAPS];
   logic signed [Y_WIDTH-1:0]      sum_c [0:TAPS];
   logic [TAPS:0]                  vld_c;
   fcf_ctl_type                    ctl [0:TAPS-1];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign tap_c[0] = sample_ff;
   assign sum_c[0] = '0;
   assign vld_c[0] = start_ff;

   for (genvar i = 0; i < TAPS; i++) begin : g_tap
      assign ctl[i].load  = req_fire && (req_cmd == CMD_LOAD) &&
                            (int'(req_coef_index) == i);
      assign ctl[i].shift = shift;

      fcf_cell #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH),
         .COEF_WIDTH  (COEF_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[i]),
         .coef_in(req_coef_value),
         .tap_in (tap_c[i]),
         .tap_out(tap_c[i+1]),
         .sum_in (sum_c[i]),
         .vld_in (vld_c[i]),
         .sum_out(sum_c[i+1]),
         .vld_out(vld_c[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_y_in     = rsp_y_ff;
      acc_in       = acc_ff;
      sample_in    = sample_ff;
      shift        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_cmd == CMD_SAMPLE)) begin
               sample_in = req_sample;
               start_in  = 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (vld_c[TAPS]) begin
               acc_in   = sum_c[TAPS];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_y_in     = acc_ff;
               shift        = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_y_ff  <= rsp_y_in;
      acc_ff    <= acc_in;
      sample_ff <= sample_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_y     = rsp_y_ff;

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (vld_c == '0))
      else $error("partial sum in flight while idle");

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(vld_c))
      else $error("more than one partial sum in the tap chain");

   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_cmd == CMD_SAMPLE)) |=> (state_ff == ST_RUN && start_ff))
      else $error("sample transfer did not launch a pass");

   a_shift_only_done: assert property (@(posedge clock) disable iff (reset)
      shift |-> (state_ff == ST_DONE && !vld_c[TAPS]))
      else $error("delay line shifted outside completion");

endmodule
